FILE: hdl/doubly_linked_list_engine_core_macros.svh
`ifndef DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define DLLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DLLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/dlle_pkg.sv
package dlle_pkg;

   localparam int ReqDataBits = 32;
   localparam int ReqUserBits = 3;
   localparam int EntryBits   = 32;
   localparam int HeldBits    = 7;
   localparam int StatusBits  = 2;
   localparam int RspDataBits = 40;

   localparam logic [ReqUserBits-1:0] FuncInsert   = 3'd0;
   localparam logic [ReqUserBits-1:0] FuncDelKey   = 3'd1;
   localparam logic [ReqUserBits-1:0] FuncDelFront = 3'd2;
   localparam logic [ReqUserBits-1:0] FuncDelBack  = 3'd3;
   localparam logic [ReqUserBits-1:0] FuncRead     = 3'd4;

   localparam logic [StatusBits-1:0] StatusDone     = 2'd0;
   localparam logic [StatusBits-1:0] StatusNotFound = 2'd1;
   localparam logic [StatusBits-1:0] StatusEmpty    = 2'd2;
   localparam logic [StatusBits-1:0] StatusFull     = 2'd3;

   typedef struct packed {
      logic [StatusBits-1:0] status;
      logic [EntryBits-1:0]  value;
      logic [HeldBits-1:0]   held;
      logic                  last;
   } rsp_type;

endpackage

FILE: hdl/dlle_ram.sv
module dlle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/dlle_out.sv
module dlle_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dlle_pkg::rsp_type load_data,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dlle_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   dlle_pkg::rsp_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: hdl/dlle_ctrl.sv
module dlle_ctrl #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dlle_pkg::ReqUserBits-1:0]     req_func,
   input  logic [dlle_pkg::ReqDataBits-1:0]     req_key,
   output logic                                 res_load,
   output dlle_pkg::rsp_type                    res_data,
   input  logic                                 out_free,
   output logic                                 val_we,
   output logic [$clog2(CAPACITY)-1:0]          val_waddr,
   output logic [VALUE_BITS-1:0]                val_wdata,
   output logic                                 next_we,
   output logic [$clog2(CAPACITY)-1:0]          next_waddr,
   output logic [$clog2(CAPACITY)-1:0]          next_wdata,
   output logic                                 prev_we,
   output logic [$clog2(CAPACITY)-1:0]          prev_waddr,
   output logic [$clog2(CAPACITY)-1:0]          prev_wdata,
   output logic                                 rd_re,
   output logic [$clog2(CAPACITY)-1:0]          rd_addr,
   input  logic [VALUE_BITS-1:0]                val_rdata,
   input  logic [$clog2(CAPACITY)-1:0]          next_rdata,
   input  logic [$clog2(CAPACITY)-1:0]          prev_rdata
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] SIdle   = 3'd0;
   localparam logic [2:0] SScan   = 3'd1;
   localparam logic [2:0] SLink   = 3'd2;
   localparam logic [2:0] SWalk   = 3'd3;
   localparam logic [2:0] SUnlink = 3'd4;
   localparam logic [2:0] SRead   = 3'd5;
   localparam logic [2:0] SEmit   = 3'd6;

   logic [2:0]                           state_ff, state_in;
   logic [SW-1:0]                        cur_ff, cur_in;
   logic [SW-1:0]                        idx_ff, idx_in;
   logic [SW-1:0]                        scan_ff, scan_in;
   logic [VALUE_BITS-1:0]                key_ff, key_in;
   logic [dlle_pkg::StatusBits-1:0]      status_ff, status_in;
   logic [SW-1:0]                        front_ff, front_in;
   logic [SW-1:0]                        back_ff, back_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic [CAPACITY-1:0]                  used_ff, used_in;

   logic signed [dlle_pkg::ReqDataBits-1:0] key_s;
   logic signed [VALUE_BITS-1:0]            val_s;
   logic                                    is_empty;
   logic                                    is_full;
   logic                                    idx_last;
   logic                                    do_unlink;

   assign key_s     = req_key;
   assign val_s     = val_rdata;
   assign is_empty  = count_ff == '0;
   assign is_full   = count_ff == CW'(CAPACITY);
   assign idx_last  = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign req_ready = state_ff == SIdle;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      scan_in    = scan_ff;
      key_in     = key_ff;
      status_in  = status_ff;
      front_in   = front_ff;
      back_in    = back_ff;
      count_in   = count_ff;
      used_in    = used_ff;
      val_we     = 1'b0;
      val_waddr  = scan_ff;
      val_wdata  = key_ff;
      next_we    = 1'b0;
      next_waddr = scan_ff;
      next_wdata = front_ff;
      prev_we    = 1'b0;
      prev_waddr = scan_ff;
      prev_wdata = scan_ff;
      rd_re      = 1'b0;
      rd_addr    = next_rdata;
      res_load   = 1'b0;
      res_data   = '{status: status_ff, value: '0,
                     held: dlle_pkg::HeldBits'(count_ff), last: 1'b1};
      do_unlink  = 1'b0;

      unique case (state_ff)
         SIdle: begin
            if (req_valid) begin
               key_in    = VALUE_BITS'(key_s);
               rd_re     = 1'b1;
               rd_addr   = (req_func == dlle_pkg::FuncDelBack) ? back_ff : front_ff;
               cur_in    = rd_addr;
               idx_in    = '0;
               scan_in   = '0;
               status_in = dlle_pkg::StatusDone;
               unique case (req_func)
                  dlle_pkg::FuncInsert: begin
                     if (is_full) begin
                        status_in = dlle_pkg::StatusFull;
                        state_in  = SEmit;
                     end else begin
                        state_in  = SScan;
                     end
                  end
                  dlle_pkg::FuncDelKey: begin
                     if (is_empty) begin
                        status_in = dlle_pkg::StatusEmpty;
                        state_in  = SEmit;
                     end else begin
                        status_in = dlle_pkg::StatusNotFound;
                        state_in  = SWalk;
                     end
                  end
                  dlle_pkg::FuncDelFront, dlle_pkg::FuncDelBack: begin
                     if (is_empty) begin
                        status_in = dlle_pkg::StatusEmpty;
                        state_in  = SEmit;
                     end else begin
                        state_in  = SUnlink;
                     end
                  end
                  dlle_pkg::FuncRead: begin
                     if (is_empty) begin
                        status_in = dlle_pkg::StatusEmpty;
                        state_in  = SEmit;
                     end else begin
                        state_in  = SRead;
                     end
                  end
                  default: begin
                     state_in = SEmit;
                  end
               endcase
            end
         end
         SScan: begin
            if (!used_ff[scan_ff] || scan_ff == SW'(CAPACITY - 1)) begin
               val_we           = 1'b1;
               next_we          = 1'b1;
               next_wdata       = is_empty ? scan_ff : front_ff;
               prev_we          = 1'b1;
               used_in[scan_ff] = 1'b1;
               cur_in           = scan_ff;
               if (is_empty) begin
                  front_in = scan_ff;
                  back_in  = scan_ff;
                  count_in = count_ff + CW'(1);
                  state_in = SEmit;
               end else begin
                  state_in = SLink;
               end
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end
         SLink: begin
            prev_we    = 1'b1;
            prev_waddr = front_ff;
            prev_wdata = cur_ff;
            front_in   = cur_ff;
            count_in   = count_ff + CW'(1);
            state_in   = SEmit;
         end
         SWalk: begin
            if (val_rdata == key_ff) begin
               do_unlink = 1'b1;
               status_in = dlle_pkg::StatusDone;
               state_in  = SEmit;
            end else if (idx_last) begin
               state_in = SEmit;
            end else begin
               cur_in = next_rdata;
               idx_in = idx_ff + SW'(1);
               rd_re  = 1'b1;
            end
         end
         SUnlink: begin
            do_unlink = 1'b1;
            state_in  = SEmit;
         end
         SRead: begin
            if (out_free) begin
               res_load = 1'b1;
               res_data = '{status: dlle_pkg::StatusDone,
                            value: dlle_pkg::EntryBits'(val_s),
                            held: dlle_pkg::HeldBits'(count_ff), last: idx_last};
               if (idx_last) begin
                  state_in = SIdle;
               end else begin
                  cur_in = next_rdata;
                  idx_in = idx_ff + SW'(1);
                  rd_re  = 1'b1;
               end
            end
         end
         SEmit: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = SIdle;
            end
         end
         default: begin
            state_in = SIdle;
         end
      endcase

      // unlink the slot under the walk pointer
      if (do_unlink) begin
         if (cur_ff == front_ff) begin
            front_in = next_rdata;
         end else begin
            next_we    = 1'b1;
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
         end
         if (cur_ff == back_ff) begin
            back_in = prev_rdata;
         end else begin
            prev_we    = 1'b1;
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
         end
         used_in[cur_ff] = 1'b0;
         count_in        = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            front_in = '0;
            back_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle;
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      scan_ff   <= scan_in;
      key_ff    <= key_in;
      status_ff <= status_in;
   end

endmodule

FILE: hdl/doubly_linked_list_engine_core.sv
// channel   dir  tdata                              tuser        tlast
// req_      in   [31:0] key_value                   [2:0] func   -
// rsp_      out  [31:0] entry_value, [38:32] held   [1:0] status last_of_run
//
// insert: scan past used slots to a free one, write the node, link it at the front
// delete by key: compare linked entries in turn; front/back delete: unlink that end
// read-out: one beat per entry, read through the single read port of the node memories
// reset clears the slot-in-use map, head, tail and count, no clearing pass
// a stalled rsp_ holds the walk; one finished beat waits in the output register
module doubly_linked_list_engine_core #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dlle_pkg::ReqDataBits-1:0]  req_tdata,   // key_value
   input  logic [dlle_pkg::ReqUserBits-1:0]  req_tuser,   // func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dlle_pkg::RspDataBits-1:0]  rsp_tdata,   // entry_value, entries_held, pad
   output logic [dlle_pkg::StatusBits-1:0]   rsp_tuser,   // status
   output logic                              rsp_tlast
);

   localparam int SW = $clog2(CAPACITY);

   logic                  val_we, next_we, prev_we, rd_re;
   logic [SW-1:0]         val_waddr, next_waddr, prev_waddr, rd_addr;
   logic [VALUE_BITS-1:0] val_wdata, val_rdata;
   logic [SW-1:0]         next_wdata, prev_wdata, next_rdata, prev_rdata;
   logic                  res_load, out_free;
   dlle_pkg::rsp_type     res_data, rsp_data;

   dlle_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
      .clock(clock), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
      .re(rd_re), .raddr(rd_addr), .rdata(val_rdata)
   );

   dlle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
      .clock(clock), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
      .re(rd_re), .raddr(rd_addr), .rdata(next_rdata)
   );

   dlle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock(clock), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
      .re(rd_re), .raddr(rd_addr), .rdata(prev_rdata)
   );

   dlle_ctrl #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready),
      .req_func(req_tuser), .req_key(req_tdata),
      .res_load(res_load), .res_data(res_data), .out_free(out_free),
      .val_we(val_we), .val_waddr(val_waddr), .val_wdata(val_wdata),
      .next_we(next_we), .next_waddr(next_waddr), .next_wdata(next_wdata),
      .prev_we(prev_we), .prev_waddr(prev_waddr), .prev_wdata(prev_wdata),
      .rd_re(rd_re), .rd_addr(rd_addr),
      .val_rdata(val_rdata), .next_rdata(next_rdata), .prev_rdata(prev_rdata)
   );

   dlle_out u_out (
      .clock(clock), .reset(reset),
      .load(res_load), .load_data(res_data), .free(out_free),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_data(rsp_data)
   );

   assign rsp_tdata = {1'b0, rsp_data.held, rsp_data.value};
   assign rsp_tuser = rsp_data.status;
   assign rsp_tlast = rsp_data.last;

endmodule

FILE: hdl/dlle_check.sv
`include "doubly_linked_list_engine_core_macros.svh"

module dlle_check #(
   parameter int CAPACITY = 64
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dlle_pkg::RspDataBits-1:0] rsp_tdata,
   input logic [dlle_pkg::StatusBits-1:0]  rsp_tuser,
   input logic                             rsp_tlast
);

   `DLLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled rsp beat changed")
   `DLLE_ASSERT_NOW(a_run_status, clock, reset, rsp_tvalid && !rsp_tlast,
      rsp_tuser == dlle_pkg::StatusDone, "non-final beat without done status")
   `DLLE_ASSERT_NOW(a_value_zero, clock, reset,
      rsp_tvalid && rsp_tuser != dlle_pkg::StatusDone,
      rsp_tdata[31:0] == 32'd0 && rsp_tlast, "failed command carries a value")
   `DLLE_ASSERT_NOW(a_empty_held, clock, reset,
      rsp_tvalid && rsp_tuser == dlle_pkg::StatusEmpty,
      rsp_tdata[38:32] == 7'd0, "empty status with entries held")
   `DLLE_ASSERT_NOW(a_full_held, clock, reset,
      rsp_tvalid && rsp_tuser == dlle_pkg::StatusFull,
      rsp_tdata[38:32] == 7'(CAPACITY), "full status below capacity")

endmodule

bind doubly_linked_list_engine_core dlle_check #(.CAPACITY(CAPACITY)) u_dlle_check (
   .clock(clock), .reset(reset),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
